// ===== rtl/urisc_pkg.sv =====
`default_nettype none

package urisc_pkg;

   // Default sizes of the machine.
   localparam int RAM_WORDS_DEF = 32768;
   localparam int DISP_W_DEF    = 128;
   localparam int DISP_H_DEF    = 64;

   // Fixed logical address map.
   localparam logic [15:0] ADDR_PC   = 16'h0000;
   localparam logic [15:0] ADDR_BANK = 16'h0001;
   localparam logic [15:0] IO_KEYB   = 16'h8000;
   localparam logic [15:0] IO_LEDS   = 16'h8001;
   localparam logic [15:0] IO_WIDTH  = 16'h8002;
   localparam logic [15:0] IO_HEIGHT = 16'h8003;
   localparam logic [15:0] PC_RESET  = 16'h0002;
   localparam int          IO_OFF_W  = 15;

   // I/O bank selector values held in word 1.
   localparam logic [15:0] BANK_CTRL  = 16'h0000;
   localparam logic [15:0] BANK_PIXEL = 16'h0001;

   // Item kinds.
   localparam logic [1:0] FUNC_EXEC = 2'd0;
   localparam logic [1:0] FUNC_KEY  = 2'd1;
   localparam logic [1:0] FUNC_LOAD = 2'd2;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 104;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  key_char;
      logic [14:0] load_addr;
      logic [15:0] load_data;
   } req_type;

   typedef struct packed {
      logic [15:0] pc_after;
      logic [15:0] acc_after;
      logic [15:0] operand_addr;
      logic [15:0] result_word;
      logic        skipped;
      logic        pixel_write;
      logic [6:0]  pixel_x;
      logic [5:0]  pixel_y;
      logic        pixel_on;
      logic        led_write;
      logic [15:0] led_value;
   } rsp_type;

   typedef struct packed {
      logic [15:0] a;
      logic [15:0] b;
      logic        cin;
   } alu_req_type;

   typedef struct packed {
      logic [15:0] sum;
      logic        carry;
   } alu_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/urisc_rssb_processor_top.sv =====
// Execute beat: steps through fetch, operand read, PC step, write-back and done states, as
// the single RAM port serves fetch, operand read and write-back in turn; the next beat is
// taken once the output is free. Key-press and load beats go straight to the done state.
// One beat is in work at a time; a new beat is taken while the previous result still
// sits in the output register. Reset is synchronous; a clearing pass then zeroes the RAM
// and no input beat is accepted until it completes.
`default_nettype none

module urisc_rssb_processor_top #(
   parameter int RAM_WORDS = urisc_pkg::RAM_WORDS_DEF,
   parameter int DISP_W    = urisc_pkg::DISP_W_DEF,
   parameter int DISP_H    = urisc_pkg::DISP_H_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // key_char[7:0], load_addr[22:8], load_data[38:23], zero pad [39]
   input  wire logic [urisc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // func[1:0]
   input  wire logic [1:0]                           req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // pc_after[15:0], acc_after[31:16], operand_addr[47:32], result_word[63:48],
   // skipped[64], pixel_write[65], pixel_x[72:66], pixel_y[78:73], pixel_on[79],
   // led_write[80], led_value[96:81], zero pad [103:97]
   output logic [urisc_pkg::RSP_TDATA_W-1:0]         rsp_tdata
);
   import urisc_pkg::*;

   localparam int AW = $clog2(RAM_WORDS);

   req_type     item;
   rsp_type     result;
   alu_req_type alu_req;
   alu_rsp_type alu_rsp;
   logic        done;
   logic        out_free;
   logic        ram_we;
   logic [AW-1:0] ram_addr;
   logic [15:0] ram_wdata;
   logic [15:0] ram_rdata;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   assign item.func      = req_tuser;
   assign item.key_char  = req_tdata[7:0];
   assign item.load_addr = req_tdata[22:8];
   assign item.load_data = req_tdata[38:23];

   urisc_ctrl #(
      .RAM_WORDS (RAM_WORDS),
      .DISP_W    (DISP_W),
      .DISP_H    (DISP_H)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item       (item),
      .out_free   (out_free),
      .done       (done),
      .result     (result),
      .alu_req    (alu_req),
      .alu_rsp    (alu_rsp),
      .ram_we     (ram_we),
      .ram_addr   (ram_addr),
      .ram_wdata  (ram_wdata),
      .ram_rdata  (ram_rdata)
   );

   urisc_alu u_alu (
      .op  (alu_req),
      .res (alu_rsp)
   );

   urisc_ram #(
      .RAM_WORDS (RAM_WORDS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Output register: frees the sequencer as soon as the result is parked.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'h00,
                        rsp_data_ff.led_value,
                        rsp_data_ff.led_write,
                        rsp_data_ff.pixel_on,
                        rsp_data_ff.pixel_y,
                        rsp_data_ff.pixel_x,
                        rsp_data_ff.pixel_write,
                        rsp_data_ff.skipped,
                        rsp_data_ff.result_word,
                        rsp_data_ff.operand_addr,
                        rsp_data_ff.acc_after,
                        rsp_data_ff.pc_after};

endmodule

`default_nettype wire

// ===== rtl/urisc_alu.sv =====
`default_nettype none

module urisc_alu (
   input  urisc_pkg::alu_req_type op,
   output urisc_pkg::alu_rsp_type res
);
   import urisc_pkg::*;

   logic [16:0] total;

   // Subtraction is done as a + ~b + 1; carry out set means no borrow.
   assign total     = {1'b0, op.a} + {1'b0, op.b} + {16'h0000, op.cin};
   assign res.sum   = total[15:0];
   assign res.carry = total[16];

endmodule

`default_nettype wire

// ===== rtl/urisc_ram.sv =====
`default_nettype none

module urisc_ram #(
   parameter int RAM_WORDS = urisc_pkg::RAM_WORDS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         we,
   input  wire logic [$clog2(RAM_WORDS)-1:0] addr,
   input  wire logic [15:0]                  wdata,
   output logic [15:0]                       rdata
);
   import urisc_pkg::*;

   logic [15:0] mem_ff [RAM_WORDS];
   logic [15:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/urisc_ctrl.sv =====
`default_nettype none

module urisc_ctrl #(
   parameter int RAM_WORDS = urisc_pkg::RAM_WORDS_DEF,
   parameter int DISP_W    = urisc_pkg::DISP_W_DEF,
   parameter int DISP_H    = urisc_pkg::DISP_H_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         item_valid,
   output logic                              item_ready,
   input  urisc_pkg::req_type                item,
   input  wire logic                         out_free,
   output logic                              done,
   output urisc_pkg::rsp_type                result,
   output urisc_pkg::alu_req_type            alu_req,
   input  urisc_pkg::alu_rsp_type            alu_rsp,
   output logic                              ram_we,
   output logic [$clog2(RAM_WORDS)-1:0]      ram_addr,
   output logic [15:0]                       ram_wdata,
   input  wire logic [15:0]                  ram_rdata
);
   import urisc_pkg::*;

   localparam int AW         = $clog2(RAM_WORDS);
   localparam int DIV_SHIFT  = IO_OFF_W + $clog2(DISP_W);
   localparam int DIV_MUL    = ((1 << DIV_SHIFT) + DISP_W - 1) / DISP_W;
   localparam int PIX_LIMIT  = DISP_W * DISP_H;
   localparam logic [15:0] DISP_W16 = 16'(DISP_W);
   localparam logic [15:0] DISP_H16 = 16'(DISP_H);

   localparam logic [2:0] S_CLR   = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_FETCH = 3'd2;
   localparam logic [2:0] S_OPER  = 3'd3;
   localparam logic [2:0] S_STEP  = 3'd4;
   localparam logic [2:0] S_WRITE = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [AW-1:0]       clr_cnt_ff, clr_cnt_in;
   logic [15:0]         pc_ff, pc_in;
   logic [15:0]         bank_ff, bank_in;
   logic [15:0]         acc_ff, acc_in;
   logic                key_ready_ff, key_ready_in;
   logic                key_lost_ff, key_lost_in;
   logic [7:0]          key_code_ff, key_code_in;
   logic [15:0]         led_ff, led_in;
   logic [15:0]         op_ff, op_in;
   logic [15:0]         res_ff, res_in;
   logic                skip_ff, skip_in;
   logic [14:0]         q_ff, q_in;
   logic [14:0]         prod_ff, prod_in;
   logic                px_w_ff, px_w_in;
   logic [6:0]          px_x_ff, px_x_in;
   logic [5:0]          px_y_ff, px_y_in;
   logic                px_on_ff, px_on_in;
   logic                led_w_ff, led_w_in;

   logic [15:0]         kbd_word;
   logic [15:0]         fetch_val;
   logic [15:0]         oper_val;
   logic [14:0]         io_off;
   logic [31:0]         prod1;
   logic [23:0]         prod2;
   logic [14:0]         xrem;
   logic                pix_ok;

   // Reads through the memory map; words 0 and 1 live in flip-flops.
   function automatic logic [15:0] rd_word(input logic [15:0] a, input logic [15:0] rdata,
                                           input logic [15:0] pc, input logic [15:0] bank,
                                           input logic [15:0] kw);
      logic [15:0] v;
      v = 16'h0000;
      if (!a[15]) begin
         if (a == ADDR_PC) v = pc;
         else if (a == ADDR_BANK) v = bank;
         else v = rdata;
      end else if (bank == BANK_CTRL) begin
         if (a == IO_KEYB) v = kw;
         else if (a == IO_WIDTH) v = DISP_W16;
         else if (a == IO_HEIGHT) v = DISP_H16;
      end
      return v;
   endfunction

   assign kbd_word  = {key_ready_ff, 3'b000, key_lost_ff, 3'b000, key_code_ff};
   assign fetch_val = rd_word(pc_ff, ram_rdata, pc_ff, bank_ff, kbd_word);
   assign oper_val  = rd_word(op_ff, ram_rdata, pc_ff, bank_ff, kbd_word);

   // Pixel offset split into row and column by a reciprocal multiply.
   assign io_off = op_ff[14:0];
   assign prod1  = 32'(io_off) * 32'(DIV_MUL);
   assign prod2  = 24'(q_ff) * 24'(DISP_W);
   assign xrem   = io_off - prod_ff;
   assign pix_ok = 32'(io_off) < 32'(PIX_LIMIT);

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      pc_in        = pc_ff;
      bank_in      = bank_ff;
      acc_in       = acc_ff;
      key_ready_in = key_ready_ff;
      key_lost_in  = key_lost_ff;
      key_code_in  = key_code_ff;
      led_in       = led_ff;
      op_in        = op_ff;
      res_in       = res_ff;
      skip_in      = skip_ff;
      q_in         = q_ff;
      prod_in      = prod_ff;
      px_w_in      = px_w_ff;
      px_x_in      = px_x_ff;
      px_y_in      = px_y_ff;
      px_on_in     = px_on_ff;
      led_w_in     = led_w_ff;
      ram_we       = 1'b0;
      ram_addr     = pc_ff[AW-1:0];
      ram_wdata    = 16'h0000;
      alu_req.a    = pc_ff;
      alu_req.b    = 16'h0000;
      alu_req.cin  = 1'b1;

      unique case (state_ff)
         S_CLR: begin
            ram_we     = 1'b1;
            ram_addr   = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(RAM_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (item_valid) begin
               op_in    = 16'h0000;
               res_in   = 16'h0000;
               skip_in  = 1'b0;
               px_w_in  = 1'b0;
               px_x_in  = 7'd0;
               px_y_in  = 6'd0;
               px_on_in = 1'b0;
               led_w_in = 1'b0;
               state_in = S_DONE;
               unique case (item.func)
                  FUNC_EXEC: begin
                     state_in = S_FETCH;
                  end
                  FUNC_KEY: begin
                     if (key_ready_ff) key_lost_in = 1'b1;
                     key_ready_in = 1'b1;
                     key_code_in  = item.key_char;
                  end
                  FUNC_LOAD: begin
                     ram_we    = 1'b1;
                     ram_addr  = item.load_addr[AW-1:0];
                     ram_wdata = item.load_data;
                     if (item.load_addr == ADDR_PC[14:0]) pc_in = item.load_data;
                     if (item.load_addr == ADDR_BANK[14:0]) bank_in = item.load_data;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FETCH: begin
            op_in    = fetch_val;
            ram_addr = fetch_val[AW-1:0];
            if (pc_ff == IO_KEYB && bank_ff == BANK_CTRL) begin
               key_ready_in = 1'b0;
               key_lost_in  = 1'b0;
            end
            state_in = S_OPER;
         end
         S_OPER: begin
            alu_req.a = oper_val;
            alu_req.b = ~acc_ff;
            res_in    = alu_rsp.sum;
            skip_in   = !alu_rsp.carry;
            q_in      = 15'(prod1 >> DIV_SHIFT);
            if (op_ff == IO_KEYB && bank_ff == BANK_CTRL) begin
               key_ready_in = 1'b0;
               key_lost_in  = 1'b0;
            end
            state_in = S_STEP;
         end
         S_STEP: begin
            alu_req.b = {15'h0000, skip_ff};
            pc_in     = alu_rsp.sum;
            prod_in   = prod2[14:0];
            state_in  = S_WRITE;
         end
         S_WRITE: begin
            acc_in = 16'h0000;
            if (!op_ff[15]) begin
               ram_we    = 1'b1;
               ram_addr  = op_ff[AW-1:0];
               ram_wdata = res_ff;
               acc_in    = res_ff;
               // A write to word 0 overrides the advanced PC.
               if (op_ff == ADDR_PC) pc_in = res_ff;
               if (op_ff == ADDR_BANK) bank_in = res_ff;
            end else if (bank_ff == BANK_CTRL) begin
               if (op_ff == IO_KEYB) begin
                  acc_in       = kbd_word;
                  key_ready_in = 1'b0;
                  key_lost_in  = 1'b0;
               end else if (op_ff == IO_LEDS) begin
                  led_in   = res_ff;
                  led_w_in = 1'b1;
                  acc_in   = res_ff;
               end else if (op_ff == IO_WIDTH) begin
                  acc_in = DISP_W16;
               end else if (op_ff == IO_HEIGHT) begin
                  acc_in = DISP_H16;
               end
            end else if (bank_ff == BANK_PIXEL) begin
               if (pix_ok) begin
                  px_w_in  = 1'b1;
                  px_x_in  = xrem[6:0];
                  px_y_in  = q_ff[5:0];
                  px_on_in = |res_ff[7:0];
                  acc_in   = res_ff;
               end
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_cnt_ff   <= '0;
         pc_ff        <= PC_RESET;
         bank_ff      <= 16'h0000;
         acc_ff       <= 16'h0000;
         key_ready_ff <= 1'b0;
         key_lost_ff  <= 1'b0;
         key_code_ff  <= 8'h00;
         led_ff       <= 16'h0000;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         pc_ff        <= pc_in;
         bank_ff      <= bank_in;
         acc_ff       <= acc_in;
         key_ready_ff <= key_ready_in;
         key_lost_ff  <= key_lost_in;
         key_code_ff  <= key_code_in;
         led_ff       <= led_in;
      end
      op_ff    <= op_in;
      res_ff   <= res_in;
      skip_ff  <= skip_in;
      q_ff     <= q_in;
      prod_ff  <= prod_in;
      px_w_ff  <= px_w_in;
      px_x_ff  <= px_x_in;
      px_y_ff  <= px_y_in;
      px_on_ff <= px_on_in;
      led_w_ff <= led_w_in;
   end

   assign item_ready = (state_ff == S_IDLE);
   assign done       = (state_ff == S_DONE) && out_free;

   assign result.pc_after     = pc_ff;
   assign result.acc_after    = acc_ff;
   assign result.operand_addr = op_ff;
   assign result.result_word  = res_ff;
   assign result.skipped      = skip_ff;
   assign result.pixel_write  = px_w_ff;
   assign result.pixel_x      = px_x_ff;
   assign result.pixel_y      = px_y_ff;
   assign result.pixel_on     = px_on_ff;
   assign result.led_write    = led_w_ff;
   assign result.led_value    = led_ff;

endmodule

`default_nettype wire

// ===== rtl/urisc_chk.sv =====
`default_nettype none

module urisc_chk (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [103:0] rsp_tdata
);
   import urisc_pkg::*;

   logic [15:0] acc_after;
   logic [15:0] operand_addr;
   logic [15:0] result_word;
   logic        pixel_write;
   logic [6:0]  pixel_x;
   logic [5:0]  pixel_y;
   logic        pixel_on;
   logic        led_write;
   logic [15:0] led_value;

   assign acc_after    = rsp_tdata[31:16];
   assign operand_addr = rsp_tdata[47:32];
   assign result_word  = rsp_tdata[63:48];
   assign pixel_write  = rsp_tdata[65];
   assign pixel_x      = rsp_tdata[72:66];
   assign pixel_y      = rsp_tdata[78:73];
   assign pixel_on     = rsp_tdata[79];
   assign led_write    = rsp_tdata[80];
   assign led_value    = rsp_tdata[96:81];

   // A beat is worked on alone, so the input closes right after acceptance.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted again in the cycle after a beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   a_led_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && led_write |->
         operand_addr == IO_LEDS && led_value == result_word && acc_after == result_word)
      else $error("LED write does not match its operand and result");

   a_pixel_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && pixel_write |-> operand_addr[15] && acc_after == result_word)
      else $error("pixel write outside the I/O area or wrong return value");

   a_pixel_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !pixel_write |-> pixel_x == 7'd0 && pixel_y == 6'd0 && !pixel_on)
      else $error("pixel fields set without a pixel write");

endmodule

bind urisc_rssb_processor_top urisc_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
